// ===== sv/qte_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the CORDIC arctangent step for the quaternion to
// angle converter. Depends on nothing.
package qte_pkg;

	localparam int DATA_W    = 16;
	localparam int QUAT_W    = 17;                // negated Q1.14 component
	localparam int PROD_W    = 2 * QUAT_W;        // Q2.28 product
	localparam int XY_W      = 38;                // CORDIC x/y with growth headroom
	localparam int ACC_W     = 33;                // Q.16 centidegree accumulator
	localparam int TABLE_LEN = 24;
	localparam int IDX_W     = 5;

	localparam logic signed [XY_W-1:0]  ONE_Q28   = XY_W'(64'sd268435456);
	localparam logic signed [ACC_W-1:0] HALF_TURN = ACC_W'(64'sd1179648000);
	localparam logic signed [ACC_W:0]   RND_HALF  = (ACC_W+1)'(64'sd32768);
	localparam logic signed [ACC_W-16:0] LIMIT_POS = (ACC_W-15)'(64'sd18000);
	localparam logic signed [ACC_W-16:0] LIMIT_NEG = -(ACC_W-15)'(64'sd18000);

	typedef logic signed [QUAT_W-1:0] quat_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	typedef struct packed {
		logic signed [XY_W-1:0]  px;
		logic signed [XY_W-1:0]  py;
		logic signed [ACC_W-1:0] acc;
		logic                    zero;
	} chan_t;

	typedef struct packed {
		chan_t cx;
		chan_t cy;
		chan_t cz;
	} trio_t;

	// atan(2^-i) in degrees scaled by 6553600
	function automatic logic signed [ACC_W-1:0] atan_step(input logic [IDX_W-1:0] idx);
		logic signed [ACC_W-1:0] r;
		unique case (idx)
			5'd0:  r = ACC_W'(64'sd294912000);
			5'd1:  r = ACC_W'(64'sd174096919);
			5'd2:  r = ACC_W'(64'sd91987925);
			5'd3:  r = ACC_W'(64'sd46694507);
			5'd4:  r = ACC_W'(64'sd23437865);
			5'd5:  r = ACC_W'(64'sd11730358);
			5'd6:  r = ACC_W'(64'sd5866610);
			5'd7:  r = ACC_W'(64'sd2933485);
			5'd8:  r = ACC_W'(64'sd1466764);
			5'd9:  r = ACC_W'(64'sd733385);
			5'd10: r = ACC_W'(64'sd366693);
			5'd11: r = ACC_W'(64'sd183347);
			5'd12: r = ACC_W'(64'sd91673);
			5'd13: r = ACC_W'(64'sd45837);
			5'd14: r = ACC_W'(64'sd22918);
			5'd15: r = ACC_W'(64'sd11459);
			5'd16: r = ACC_W'(64'sd5730);
			5'd17: r = ACC_W'(64'sd2865);
			5'd18: r = ACC_W'(64'sd1432);
			5'd19: r = ACC_W'(64'sd716);
			5'd20: r = ACC_W'(64'sd358);
			5'd21: r = ACC_W'(64'sd179);
			5'd22: r = ACC_W'(64'sd90);
			5'd23: r = ACC_W'(64'sd45);
			default: r = '0;
		endcase
		return r;
	endfunction

	// One vectoring rotation: drive py towards zero
	function automatic chan_t cordic_iter(input chan_t c, input logic [IDX_W-1:0] idx);
		chan_t                  r;
		logic signed [XY_W-1:0] sx;
		logic signed [XY_W-1:0] sy;
		sx = c.px >>> idx;
		sy = c.py >>> idx;
		r  = c;
		if (c.py > 0) begin
			r.px  = c.px + sy;
			r.py  = c.py - sx;
			r.acc = c.acc + atan_step(idx);
		end else begin
			r.px  = c.px - sy;
			r.py  = c.py + sx;
			r.acc = c.acc - atan_step(idx);
		end
		return r;
	endfunction

	// Fold a negative denominator into the right half plane
	function automatic chan_t pre_rotate(input logic signed [XY_W-1:0] num,
			input logic signed [XY_W-1:0] den);
		chan_t r;
		r.zero = (num == '0) && (den == '0);
		if (den < 0) begin
			r.acc = (num >= 0) ? HALF_TURN : -HALF_TURN;
			r.px  = -den;
			r.py  = -num;
		end else begin
			r.acc = '0;
			r.px  = den;
			r.py  = num;
		end
		return r;
	endfunction

	// Round half up to whole centidegrees, then clamp
	function automatic logic signed [DATA_W-1:0] finish(input chan_t c);
		logic signed [ACC_W:0]    sum;
		logic signed [ACC_W-16:0] rnd;
		logic signed [DATA_W-1:0] r;
		sum = (ACC_W+1)'(c.acc) + RND_HALF;
		rnd = sum[ACC_W:16];
		if (c.zero)
			r = '0;
		else if (rnd > LIMIT_POS)
			r = DATA_W'(LIMIT_POS);
		else if (rnd < LIMIT_NEG)
			r = DATA_W'(LIMIT_NEG);
		else
			r = rnd[DATA_W-1:0];
		return r;
	endfunction

endpackage

// ===== sv/qte_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channels for quaternion items in and angle triples out.
// Depends on qte_pkg for the field width.
interface qte_quat_if;
	logic                              valid;
	logic                              ready;
	logic signed [qte_pkg::DATA_W-1:0] quat_w;
	logic signed [qte_pkg::DATA_W-1:0] quat_x;
	logic signed [qte_pkg::DATA_W-1:0] quat_y;
	logic signed [qte_pkg::DATA_W-1:0] quat_z;
	modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
	modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_angle_if;
	logic                              valid;
	logic                              ready;
	logic signed [qte_pkg::DATA_W-1:0] angle_x;
	logic signed [qte_pkg::DATA_W-1:0] angle_y;
	logic signed [qte_pkg::DATA_W-1:0] angle_z;
	modport source (output valid, angle_x, angle_y, angle_z, input ready);
	modport sink (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

// ===== sv/quaternion_to_euler_angles.sv =====
`timescale 1ns / 1ps
// Quaternion to three axis angles: multiply, sum, then one CORDIC pipeline per axis.
// Depends on qte_pkg and the channel interfaces in qte_if.
//
// Takes one quaternion (w, x, y, z, signed Q1.14) per clock and returns three
// angles in hundredths of a degree, each an atan2 of the products with x, y and
// z negated; the y angle is an atan2, not an asin. The stages are negate,
// multiply, sum, quadrant fold, one register per CORDIC rotation, then rounding
// and clamp. Throughput is one item per clock while the output is not stalled;
// every stage holds a valid bit and a stall fills bubbles before it stops the input.
module quaternion_to_euler_angles #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic clk,
	input  logic arst_n,
	qte_quat_if.sink    quat,
	qte_angle_if.source angle
);

	localparam int N     = (CORDIC_STEPS < qte_pkg::TABLE_LEN) ? CORDIC_STEPS
		: qte_pkg::TABLE_LEN;
	localparam int DEPTH = N + 5;

	logic [DEPTH-1:0] valid_s;
	logic [DEPTH-1:0] adv;

	// a stage loads when it is empty or the next one moves on
	always_comb begin
		adv[DEPTH-1] = !valid_s[DEPTH-1] || angle.ready;
		for (int k = DEPTH - 2; k >= 0; k--)
			adv[k] = !valid_s[k] || adv[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			if (adv[0])
				valid_s[0] <= quat.valid;
			for (int k = 1; k < DEPTH; k++)
				if (adv[k])
					valid_s[k] <= valid_s[k-1];
		end
	end

	assign quat.ready  = adv[0];
	assign angle.valid = valid_s[DEPTH-1];

	// stage 1: negate the vector part
	qte_pkg::quat_t w_s1, x_s1, y_s1, z_s1;
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			w_s1 <= qte_pkg::QUAT_W'(quat.quat_w);
			x_s1 <= -qte_pkg::QUAT_W'(quat.quat_x);
			y_s1 <= -qte_pkg::QUAT_W'(quat.quat_y);
			z_s1 <= -qte_pkg::QUAT_W'(quat.quat_z);
		end
	end

	// stage 2: products
	qte_pkg::prod_t xx_s2, yy_s2, zz_s2, yz_s2, wx_s2, xz_s2, wy_s2, xy_s2, wz_s2;
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			xx_s2 <= x_s1 * x_s1;
			yy_s2 <= y_s1 * y_s1;
			zz_s2 <= z_s1 * z_s1;
			yz_s2 <= y_s1 * z_s1;
			wx_s2 <= w_s1 * x_s1;
			xz_s2 <= x_s1 * z_s1;
			wy_s2 <= w_s1 * y_s1;
			xy_s2 <= x_s1 * y_s1;
			wz_s2 <= w_s1 * z_s1;
		end
	end

	// stage 3: numerators and denominators
	logic signed [qte_pkg::XY_W-1:0] num_x_s3, num_y_s3, num_z_s3, den_xy_s3, den_xz_s3;
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			num_x_s3  <= (qte_pkg::XY_W'(yz_s2) - qte_pkg::XY_W'(wx_s2)) <<< 1;
			num_y_s3  <= -((qte_pkg::XY_W'(xz_s2) + qte_pkg::XY_W'(wy_s2)) <<< 1);
			num_z_s3  <= -((qte_pkg::XY_W'(xy_s2) + qte_pkg::XY_W'(wz_s2)) <<< 1);
			den_xy_s3 <= qte_pkg::ONE_Q28
				- ((qte_pkg::XY_W'(xx_s2) + qte_pkg::XY_W'(yy_s2)) <<< 1);
			den_xz_s3 <= qte_pkg::ONE_Q28
				- ((qte_pkg::XY_W'(xx_s2) + qte_pkg::XY_W'(zz_s2)) <<< 1);
		end
	end

	// stage 4 onwards: quadrant fold then one rotation per stage
	qte_pkg::trio_t cor_s [N+1];
	always_ff @(posedge clk) begin
		if (adv[3]) begin
			cor_s[0].cx <= qte_pkg::pre_rotate(num_x_s3, den_xy_s3);
			cor_s[0].cy <= qte_pkg::pre_rotate(num_y_s3, den_xy_s3);
			cor_s[0].cz <= qte_pkg::pre_rotate(num_z_s3, den_xz_s3);
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cordic
		localparam logic [qte_pkg::IDX_W-1:0] IDX = qte_pkg::IDX_W'(i);
		always_ff @(posedge clk) begin
			if (adv[4+i]) begin
				cor_s[i+1].cx <= qte_pkg::cordic_iter(cor_s[i].cx, IDX);
				cor_s[i+1].cy <= qte_pkg::cordic_iter(cor_s[i].cy, IDX);
				cor_s[i+1].cz <= qte_pkg::cordic_iter(cor_s[i].cz, IDX);
			end
		end
	end

	// last stage: round, clamp and hold for the output transfer
	logic signed [qte_pkg::DATA_W-1:0] ang_x_q, ang_y_q, ang_z_q;
	always_ff @(posedge clk) begin
		if (adv[DEPTH-1]) begin
			ang_x_q <= qte_pkg::finish(cor_s[N].cx);
			ang_y_q <= qte_pkg::finish(cor_s[N].cy);
			ang_z_q <= qte_pkg::finish(cor_s[N].cz);
		end
	end

	assign angle.angle_x = ang_x_q;
	assign angle.angle_y = ang_y_q;
	assign angle.angle_z = ang_z_q;

	// an empty output stage lets the whole pipeline move
	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!angle.valid |-> quat.ready)
		else $error("input stalled with an empty output stage");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		angle.valid |-> (angle.angle_x <= 18000 && angle.angle_x >= -18000
			&& angle.angle_y <= 18000 && angle.angle_y >= -18000
			&& angle.angle_z <= 18000 && angle.angle_z >= -18000))
		else $error("angle outside half turn");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[DEPTH-1] && !angle.ready |=> valid_s[DEPTH-1])
		else $error("unsent result dropped");

endmodule

// ===== tb/quaternion_to_euler_angles_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for quaternion_to_euler_angles: a directed table, then random
// quaternions, each checked against a CORDIC angle predictor. Depends on qte_pkg and qte_if.
module quaternion_to_euler_angles_test;

	localparam int STEPS     = 16;
	localparam int N_RANDOM  = 1830;
	localparam int CALM_FROM = 1500;
	localparam int LIMIT     = 400000;

	typedef struct {
		logic signed [15:0] w, x, y, z;
		bit                 known;
		logic signed [15:0] ex, ey, ez;
	} quat_row_t;

	typedef struct {
		logic signed [15:0] ax, ay, az;
	} angles_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	qte_quat_if  quat ();
	qte_angle_if angle ();

	quaternion_to_euler_angles #(.CORDIC_STEPS(STEPS)) dut (
		.clk(clk), .arst_n(arst_n), .quat(quat), .angle(angle)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	angles_t   pending_angles[$];
	quat_row_t directed[$];
	int        failures = 0;
	int        cycles = 0;
	bit        calm = 1'b0;
	bit        sent_all = 1'b0;

	function automatic longint ashr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic logic signed [15:0] cordic_angle(longint num, longint den);
		longint atan_lut[24] = '{294912000, 174096919, 91987925, 46694507, 23437865,
			11730358, 5866610, 2933485, 1466764, 733385, 366693, 183347, 91673, 45837,
			22918, 11459, 5730, 2865, 1432, 716, 358, 179, 90, 45};
		longint px, py, acc, sx, sy, r;
		px = den;
		py = num;
		acc = 0;
		if (px == 0 && py == 0)
			return 16'sd0;
		if (px < 0) begin
			acc = (py >= 0) ? 64'sd1179648000 : -64'sd1179648000;
			px = -px;
			py = -py;
		end
		for (int i = 0; i < STEPS && i < 24; i++) begin
			sx = ashr(px, i);
			sy = ashr(py, i);
			if (py > 0) begin
				px = px + sy;
				py = py - sx;
				acc += atan_lut[i];
			end else begin
				px = px - sy;
				py = py + sx;
				acc -= atan_lut[i];
			end
		end
		r = ashr(acc + 32768, 16);
		if (r > 18000)
			r = 18000;
		if (r < -18000)
			r = -18000;
		return 16'(r);
	endfunction

	function automatic angles_t predict_angles(logic signed [15:0] qw, logic signed [15:0] qx,
			logic signed [15:0] qy, logic signed [15:0] qz);
		longint w, x, y, z, den_xy, den_xz;
		angles_t a;
		w = qw;
		x = -longint'(qx);
		y = -longint'(qy);
		z = -longint'(qz);
		den_xy = (64'sd1 <<< 28) - 2 * (x * x + y * y);
		den_xz = (64'sd1 <<< 28) - 2 * (x * x + z * z);
		a.ax = cordic_angle(2 * (y * z - w * x), den_xy);
		a.ay = cordic_angle(-2 * (x * z + w * y), den_xy);
		a.az = cordic_angle(-2 * (x * y + w * z), den_xz);
		return a;
	endfunction

	function automatic void add_row(int w, int x, int y, int z, bit known = 0,
			int ex = 0, int ey = 0, int ez = 0);
		quat_row_t r;
		r.w = 16'(w); r.x = 16'(x); r.y = 16'(y); r.z = 16'(z);
		r.known = known;
		r.ex = 16'(ex); r.ey = 16'(ey); r.ez = 16'(ez);
		directed.push_back(r);
	endfunction

	task automatic send_quat(logic signed [15:0] w, x, y, z);
		angles_t a;
		if (!calm && $urandom_range(0, 5) == 0) begin
			quat.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		quat.valid <= 1'b1;
		quat.quat_w <= w;
		quat.quat_x <= x;
		quat.quat_y <= y;
		quat.quat_z <= z;
		@(posedge clk);
		while (!quat.ready)
			@(posedge clk);
		a = predict_angles(w, x, y, z);
		pending_angles.push_back(a);
	endtask

	// random Q1.14 component: mostly in range, sometimes any 16-bit pattern
	function automatic logic signed [15:0] rand_comp();
		unique case ($urandom_range(0, 9))
			0: return 16'($urandom);
			1: return ($urandom_range(0, 1)) ? 16'sd16384 : -16'sd16384;
			2: return 16'sd0;
			default: return 16'($signed($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	initial begin
		quat.valid = 1'b0;
		quat.quat_w = '0; quat.quat_x = '0; quat.quat_y = '0; quat.quat_z = '0;
		angle.ready = 1'b0;
		// identity and origin cases
		add_row(16384, 0, 0, 0, 1, 0, 0, 0);
		add_row(0, 0, 0, 0, 1, 0, 0, 0);
		add_row(-16384, 0, 0, 0, 1, 0, 0, 0);
		// half turns about each axis: negative real axis gives +18000
		add_row(0, 16384, 0, 0, 1, 18000, 18000, 18000);
		add_row(0, 0, 16384, 0, 1, 18000, 18000, 0);
		add_row(0, 0, 0, 16384, 1, 0, 0, 18000);
		add_row(0, -16384, 0, 0, 1, 18000, 18000, 18000);
		add_row(11585, 11585, 0, 0);
		add_row(11585, 0, 11585, 0);
		add_row(11585, 0, 0, 11585);
		add_row(11585, -11585, 0, 0);
		add_row(8192, 8192, 8192, 8192);
		add_row(8192, -8192, 8192, -8192);
		add_row(32767, 32767, 32767, 32767);
		add_row(-32768, -32768, -32768, -32768);
		add_row(32767, -32768, 32767, -32768);
		add_row(-1, -1, -1, -1);
		add_row(1, 1, 1, 1);
		add_row(16384, 16384, 16384, 16384);
		add_row(-16384, 16384, -16384, 16384);
		add_row(0, 16384, 16384, 16384);
		add_row(21845, -21845, 10923, 5461);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) begin
			send_quat(directed[i].w, directed[i].x, directed[i].y, directed[i].z);
			if (directed[i].known) begin
				angles_t a;
				a = pending_angles[$];
				if (a.ax !== directed[i].ex || a.ay !== directed[i].ey
						|| a.az !== directed[i].ez) begin
					$display("%0t: row %0d table expects %0d %0d %0d, predictor %0d %0d %0d",
						$time, i, directed[i].ex, directed[i].ey, directed[i].ez,
						a.ax, a.ay, a.az);
					failures++;
				end
			end
		end
		// hold off until the pipeline has drained
		quat.valid <= 1'b0;
		@(posedge clk);
		while (pending_angles.size() != 0)
			@(posedge clk);
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == CALM_FROM)
				calm = 1'b1;
			send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
		end
		quat.valid <= 1'b0;
		sent_all = 1'b1;
	end

	// sink: random stall bursts, none near the end
	initial begin
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				stall--;
				angle.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall = $urandom_range(1, 19) - 1;
				angle.ready <= 1'b0;
			end else begin
				angle.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		angles_t a;
		if (arst_n && angle.valid && angle.ready) begin
			if (pending_angles.size() == 0) begin
				$display("%0t: unexpected transfer %0d %0d %0d", $time,
					angle.angle_x, angle.angle_y, angle.angle_z);
				failures++;
			end else begin
				a = pending_angles.pop_front();
				if (angle.angle_x !== a.ax || angle.angle_y !== a.ay
						|| angle.angle_z !== a.az) begin
					$display("%0t: expected %0d %0d %0d, got %0d %0d %0d", $time,
						a.ax, a.ay, a.az, angle.angle_x, angle.angle_y, angle.angle_z);
					failures++;
				end
			end
		end
	end

	initial begin
		while (!(sent_all && pending_angles.size() == 0) && cycles < LIMIT)
			@(posedge clk);
		if (cycles < LIMIT) begin
			repeat (STEPS + 10) @(posedge clk);
			if (failures == 0)
				$display("simulation ok");
			else
				$display("simulation failed");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	always @(posedge clk)
		cycles <= cycles + 1;

endmodule

// ===== quaternion_to_euler_angles.f =====
sv/qte_pkg.sv
sv/qte_if.sv
sv/quaternion_to_euler_angles.sv
tb/quaternion_to_euler_angles_test.sv
